/* hw/rtl/brac_pkg.sv */
// Package for the radix text converter: widths, ASCII codes, controller states
// and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block but brac_ram uses it.
package brac_pkg;

	// Width of the input value and size of the digit store.
	localparam int VALUE_WIDTH = 32;
	localparam int MAX_DIGITS  = 32;

	// Quotient bits resolved per divider cycle and divider chunks per digit.
	localparam int STEP_BITS = 8;
	localparam int CHUNKS    = VALUE_WIDTH / STEP_BITS;
	localparam int CHUNK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	// Digit store addressing.
	localparam int IDX_W = $clog2(MAX_DIGITS);

	// Field widths.
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	// Radix register reset value and the range the divider works in.
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;

	// ASCII codes.
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_F     = 7'h46;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} brac_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic emit_sign;
		logic emit_digit;
	} brac_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic digit_done;
		logic neg;
		logic out_free;
		logic ptr_zero;
	} brac_sts_t;

	// Maps a digit value to its ASCII character, 0-9 then A-F.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
		end
		return c;
	endfunction

endpackage

/* hw/rtl/brac_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module brac_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* hw/rtl/brac_ctrl.sv */
// Controller of the radix text converter: sequences accept, division,
// sign and digit output. Depends on brac_pkg.
module brac_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  brac_pkg::brac_sts_t sts,
	output brac_pkg::brac_cmd_t cmd
);

	brac_pkg::brac_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brac_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			brac_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = brac_pkg::ST_DIV;
				end
			end
			brac_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.digit_done) begin
					state_d = sts.neg ? brac_pkg::ST_SIGN : brac_pkg::ST_READ;
				end
			end
			brac_pkg::ST_SIGN: begin
				if (sts.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = brac_pkg::ST_READ;
				end
			end
			brac_pkg::ST_READ: begin
				// The store address is presented here; data is valid next cycle.
				state_d = brac_pkg::ST_EMIT;
			end
			brac_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.ptr_zero) begin
						state_d = brac_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = brac_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/brac_dp.sv */
// Datapath of the radix text converter: radix register, digit divider,
// digit store and output register. Depends on brac_pkg and brac_ram.
module brac_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 radix_wr_en,
	input  logic [brac_pkg::RADIX_W-1:0]         radix_wr_data,
	input  logic signed [brac_pkg::VALUE_WIDTH-1:0] value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [brac_pkg::CHAR_W-1:0]          character,
	output logic                                 last_char,
	input  brac_pkg::brac_cmd_t                  cmd,
	output brac_pkg::brac_sts_t                  sts
);

	logic [brac_pkg::RADIX_W-1:0]     radix_q;
	logic [brac_pkg::RADIX_W-1:0]     base_eff;
	logic [brac_pkg::RADIX_W-1:0]     base_q;
	logic [brac_pkg::VALUE_WIDTH-1:0] residual_q;
	logic [brac_pkg::VALUE_WIDTH-1:0] residual_d;
	logic [brac_pkg::VALUE_WIDTH-1:0] magnitude;
	logic [brac_pkg::DIGIT_W-1:0]     rem_q;
	logic [brac_pkg::DIGIT_W-1:0]     rem_d;
	logic [brac_pkg::STEP_BITS-1:0]   qbits;
	logic [brac_pkg::RADIX_W-1:0]     trial;
	logic [brac_pkg::CHUNK_W-1:0]     chunk_q;
	logic                             chunk_last;
	logic [brac_pkg::IDX_W-1:0]       count_q;
	logic [brac_pkg::IDX_W-1:0]       ptr_q;
	logic [brac_pkg::IDX_W-1:0]       rd_addr;
	logic [brac_pkg::DIGIT_W-1:0]     rd_digit;
	logic                             neg_q;
	logic                             neg_d;
	logic                             digit_wr;
	logic                             out_valid_q;
	logic [brac_pkg::CHAR_W-1:0]      char_q;
	logic                             last_q;

	// Radix register; the user must write it only while the block is idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= brac_pkg::RADIX_RESET;
		end else if (radix_wr_en) begin
			radix_q <= radix_wr_data;
		end
	end

	// Saturate the radix into the supported range of 2 to 16.
	always_comb begin
		if (radix_q < brac_pkg::RADIX_MIN) begin
			base_eff = brac_pkg::RADIX_MIN;
		end else if (radix_q > brac_pkg::RADIX_MAX) begin
			base_eff = brac_pkg::RADIX_MAX;
		end else begin
			base_eff = radix_q;
		end
	end

	// A negative value in base ten is printed as a sign and its magnitude.
	assign neg_d     = value[brac_pkg::VALUE_WIDTH-1] && (base_eff == brac_pkg::RADIX_DEC);
	assign magnitude = neg_d ? (brac_pkg::VALUE_WIDTH'(0) - brac_pkg::VALUE_WIDTH'(value))
	                         : brac_pkg::VALUE_WIDTH'(value);

	// Long division by the base: one chunk of quotient bits per cycle.
	always_comb begin
		rem_d = rem_q;
		qbits = '0;
		trial = '0;
		for (int i = 0; i < brac_pkg::STEP_BITS; i++) begin
			trial = {rem_d, residual_q[brac_pkg::VALUE_WIDTH-1-i]};
			if (trial >= base_q) begin
				qbits[brac_pkg::STEP_BITS-1-i] = 1'b1;
				trial = trial - base_q;
			end
			rem_d = trial[brac_pkg::DIGIT_W-1:0];
		end
		residual_d = {residual_q[brac_pkg::VALUE_WIDTH-brac_pkg::STEP_BITS-1:0], qbits};
	end

	assign chunk_last = (chunk_q == brac_pkg::CHUNK_W'(brac_pkg::CHUNKS - 1));
	assign digit_wr   = cmd.div_step && chunk_last;

	// Division control registers, digit count and read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residual_q <= '0;
			rem_q      <= '0;
			chunk_q    <= '0;
			count_q    <= '0;
			ptr_q      <= '0;
			neg_q      <= 1'b0;
			base_q     <= brac_pkg::RADIX_RESET;
		end else begin
			if (cmd.load) begin
				residual_q <= magnitude;
				rem_q      <= '0;
				chunk_q    <= '0;
				count_q    <= '0;
				neg_q      <= neg_d;
				base_q     <= base_eff;
			end else if (cmd.div_step) begin
				residual_q <= residual_d;
				if (chunk_last) begin
					// Digit finished: store it and restart the remainder.
					rem_q   <= '0;
					chunk_q <= '0;
					count_q <= count_q + brac_pkg::IDX_W'(1);
					ptr_q   <= count_q;
				end else begin
					rem_q   <= rem_d;
					chunk_q <= chunk_q + brac_pkg::CHUNK_W'(1);
				end
			end else if (cmd.emit_digit) begin
				ptr_q <= ptr_q - brac_pkg::IDX_W'(1);
			end
		end
	end

	// Digits are read back most significant first; the address runs ahead on output.
	assign rd_addr = cmd.emit_digit ? (ptr_q - brac_pkg::IDX_W'(1)) : ptr_q;

	brac_ram #(
		.WIDTH(brac_pkg::DIGIT_W),
		.DEPTH(brac_pkg::MAX_DIGITS)
	) u_digit_store (
		.clk    (clk),
		.wr_en  (digit_wr),
		.wr_addr(count_q),
		.wr_data(rem_d),
		.rd_addr(rd_addr),
		.rd_data(rd_digit)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= brac_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= brac_pkg::digit_char(rd_digit);
			last_q <= (ptr_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last_char = last_q;

	// Status back to the controller.
	assign sts.digit_done = digit_wr &&
	                        ((residual_d == '0) ||
	                         (count_q == brac_pkg::IDX_W'(brac_pkg::MAX_DIGITS - 1)));
	assign sts.neg        = neg_q;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.ptr_zero   = (ptr_q == '0);

endmodule

/* hw/rtl/binary_to_radix_ascii.sv */
// Top level of the radix text converter: controller plus datapath.
// Depends on brac_pkg, brac_ctrl, brac_dp and brac_ram.
//
// Usage: an input beat carries a 32-bit signed value on in_valid/in_ready.
// The block returns its text as one output beat per ASCII character on
// out_valid/out_ready, most significant digit first, with last_char set on
// the final character. The base comes from the radix register, written with
// radix_wr_en/radix_wr_data while the block is idle; values below 2 act as
// base 2 and values above 16 as base 16. In base 10 a negative value is
// preceded by '-'; other bases read the value as unsigned.
// Timing: the divider resolves 8 quotient bits per cycle and writes each digit to
// the digit store. The store is then read back, and characters leave at one per
// cycle while the receiver is ready, with a sign character first if there is one.
// One item is converted at a time; the next beat is taken once the last
// character sits in the output register, even while it still waits.
// Reset clears the control state and sets the radix to 10. A stalled receiver
// holds the current character and pauses the readout without losing data.
module binary_to_radix_ascii (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    radix_wr_en,
	input  logic [brac_pkg::RADIX_W-1:0]            radix_wr_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [brac_pkg::VALUE_WIDTH-1:0] value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [brac_pkg::CHAR_W-1:0]             character,
	output logic                                    last_char
);

	brac_pkg::brac_cmd_t cmd;
	brac_pkg::brac_sts_t sts;

	// Sequencer.
	brac_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Divider, digit store and output register.
	brac_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix_wr_en  (radix_wr_en),
		.radix_wr_data(radix_wr_data),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.character    (character),
		.last_char    (last_char),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

/* hw/rtl/brac_checker.sv */
// Port-level checks for the radix text converter, bound to its top level.
// Depends on brac_pkg and binary_to_radix_ascii.
module brac_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic [brac_pkg::CHAR_W-1:0]             character,
	input logic                                    last_char
);

	// An output beat stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// Every character is a sign, a decimal digit or a letter A to F.
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == brac_pkg::CHAR_MINUS) ||
		              (character >= brac_pkg::CHAR_ZERO && character <= brac_pkg::CHAR_NINE) ||
		              (character >= brac_pkg::CHAR_A && character <= brac_pkg::CHAR_F))
		else $error("illegal output character");

	// A sign is never the final character of a number.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (character == brac_pkg::CHAR_MINUS) |-> !last_char)
		else $error("sign flagged as last character");

	// After an input beat the block is busy converting it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again during a conversion");

endmodule

bind binary_to_radix_ascii brac_checker u_brac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.character(character),
	.last_char(last_char)
);

/* dv/radix_text_checker.sv */
// Checker for the radix text converter: follows the radix register, predicts the
// text of every accepted value and compares each output beat with it.
// Depends on brac_pkg; instantiated beside the block by the testbench top.
module radix_text_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    radix_wr_en,
	input  logic [brac_pkg::RADIX_W-1:0]            radix_wr_data,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic signed [brac_pkg::VALUE_WIDTH-1:0] value,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic [brac_pkg::CHAR_W-1:0]             character,
	input  logic                                    last_char,
	output int                                      fail_count,
	output int                                      outstanding
);

	// One character beat of the expected text.
	typedef struct packed {
		logic [brac_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} text_beat_t;

	localparam string DIGIT_GLYPHS = "0123456789ABCDEF";

	text_beat_t                   pending_text[$];
	logic [brac_pkg::RADIX_W-1:0] radix_shadow;
	int                           mismatches;

	// Appends the text of one value, most significant character first.
	task automatic predict_text(input logic [brac_pkg::VALUE_WIDTH-1:0] v,
		input logic [brac_pkg::RADIX_W-1:0] r);
		logic [brac_pkg::VALUE_WIDTH-1:0] base;
		logic [brac_pkg::VALUE_WIDTH-1:0] magnitude;
		logic [brac_pkg::DIGIT_W-1:0]     digits[brac_pkg::MAX_DIGITS];
		byte                              glyph;
		text_beat_t                       beat;
		int                               n;
		// Out-of-range bases saturate to 2 or 16.
		if (r < brac_pkg::RADIX_MIN) begin
			base = brac_pkg::VALUE_WIDTH'(brac_pkg::RADIX_MIN);
		end else if (r > brac_pkg::RADIX_MAX) begin
			base = brac_pkg::VALUE_WIDTH'(brac_pkg::RADIX_MAX);
		end else begin
			base = brac_pkg::VALUE_WIDTH'(r);
		end
		// Only decimal is signed; the magnitude wraps, so the most negative value works.
		magnitude = v;
		if (v[brac_pkg::VALUE_WIDTH-1] &&
		    base == brac_pkg::VALUE_WIDTH'(brac_pkg::RADIX_DEC)) begin
			beat.ch = brac_pkg::CHAR_MINUS;
			beat.last = 1'b0;
			pending_text.push_back(beat);
			magnitude = -v;
		end
		// Repeated division gives the digits least significant first.
		n = 0;
		do begin
			digits[n] = brac_pkg::DIGIT_W'(magnitude % base);
			n++;
			magnitude = magnitude / base;
		end while (magnitude != 0 && n < brac_pkg::MAX_DIGITS);
		for (int i = n - 1; i >= 0; i--) begin
			glyph = DIGIT_GLYPHS[digits[i]];
			beat.ch = glyph[brac_pkg::CHAR_W-1:0];
			beat.last = (i == 0);
			pending_text.push_back(beat);
		end
	endtask

	// Compare output beats first, then record the new value, then the register write.
	always @(posedge clk or negedge arst_n) begin
		text_beat_t want;
		if (!arst_n) begin
			radix_shadow = brac_pkg::RADIX_RESET;
			pending_text.delete();
			fail_count = 0;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_text.size() == 0) begin
					fail_count++;
					if (mismatches < 10) begin
						$display("unexpected beat: character %h last_char %b", character,
							last_char);
					end
					mismatches++;
				end else begin
					want = pending_text.pop_front();
					if (character !== want.ch || last_char !== want.last) begin
						fail_count++;
						if (mismatches < 10) begin
							$display("beat mismatch: expected %h/%b, got %h/%b", want.ch,
								want.last, character, last_char);
						end
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_text(value, radix_shadow);
			end
			if (radix_wr_en) begin
				radix_shadow = radix_wr_data;
			end
			outstanding <= pending_text.size();
		end
	end

endmodule

/* dv/testbench.sv */
// Testbench top for the radix text converter: clock, reset, register writes,
// value stimulus with random idling on both sides, and the verdict.
// Depends on brac_pkg, binary_to_radix_ascii and radix_text_checker.
module testbench;

	logic                                    clk = 1'b0;
	logic                                    arst_n = 1'b0;
	logic                                    radix_wr_en = 1'b0;
	logic [brac_pkg::RADIX_W-1:0]            radix_wr_data = '0;
	logic                                    in_valid = 1'b0;
	logic                                    in_ready;
	logic signed [brac_pkg::VALUE_WIDTH-1:0] value = '0;
	logic                                    out_valid;
	logic                                    out_ready = 1'b0;
	logic [brac_pkg::CHAR_W-1:0]             character;
	logic                                    last_char;
	int                                      fail_count;
	int                                      outstanding;
	int                                      tx_burst = 0;
	int                                      rx_burst = 0;

	always #5 clk = ~clk;

	binary_to_radix_ascii uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix_wr_en  (radix_wr_en),
		.radix_wr_data(radix_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.character    (character),
		.last_char    (last_char)
	);

	radix_text_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix_wr_en  (radix_wr_en),
		.radix_wr_data(radix_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.character    (character),
		.last_char    (last_char),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// Offers one value after a random gap and returns at the edge that accepts it.
	task automatic send_value(input logic [brac_pkg::VALUE_WIDTH-1:0] v);
		int gap;
		if (tx_burst > 0) begin
			gap = 0;
			tx_burst--;
		end else if ($urandom_range(0, 15) == 0) begin
			gap = 0;
			tx_burst = $urandom_range(10, 40);
		end else begin
			gap = $urandom_range(0, 19);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Waits until all text has come out, then writes the radix register.
	task automatic set_radix(input logic [brac_pkg::RADIX_W-1:0] r);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		radix_wr_en <= 1'b1;
		radix_wr_data <= r;
		@(posedge clk);
		radix_wr_en <= 1'b0;
	endtask

	// Receiver: random stalls per beat, idle-free stretches and one long hold-off.
	initial begin
		int gap;
		int beats;
		bit held;
		beats = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_burst > 0) begin
				gap = 0;
				rx_burst--;
			end else if ($urandom_range(0, 15) == 0) begin
				gap = 0;
				rx_burst = $urandom_range(10, 40);
			end else begin
				gap = $urandom_range(0, 19);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			beats++;
			// Hold the output long enough that the block stops taking values.
			if (beats == 400 && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
			end
		end
	end

	// Stimulus: directed corner values, then random phases with varied radix.
	initial begin
		logic [brac_pkg::RADIX_W-1:0]     phase_radix;
		logic [brac_pkg::VALUE_WIDTH-1:0] v;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset radix is decimal: signs, extremes and digit-count boundaries.
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'hFFFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'h8000_0001);
		send_value(32'd9);
		send_value(32'd10);
		send_value(32'hFFFF_FFF6);
		send_value(32'd1000000000);
		// Binary gives the longest text.
		set_radix(5'd2);
		send_value(32'hFFFF_FFFF);
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'h8000_0000);
		// Hexadecimal covers every letter; negative values read as unsigned.
		set_radix(5'd16);
		send_value(32'hFEDC_BA98);
		send_value(32'h0123_4567);
		send_value(32'hABCD_EF00);
		// Radix values outside 2..16 saturate; then base 8 on the most negative value.
		set_radix(5'd0);
		send_value(32'd5);
		set_radix(5'd1);
		send_value(32'd6);
		set_radix(5'd17);
		send_value(32'd255);
		set_radix(5'd31);
		send_value(32'hFFFF_FFFF);
		set_radix(5'd8);
		send_value(32'h8000_0000);

		// Random phases, each with its own radix.
		for (int p = 0; p < 12; p++) begin
			case (p)
				0: phase_radix = 5'd2;
				1: phase_radix = 5'd16;
				2: phase_radix = 5'd10;
				3: phase_radix = 5'd31;
				4: phase_radix = 5'd0;
				5: phase_radix = 5'd7;
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						phase_radix = 5'd10;
					end else begin
						phase_radix = brac_pkg::RADIX_W'($urandom_range(0, 31));
					end
				end
			endcase
			set_radix(phase_radix);
			for (int k = 0; k < 30; k++) begin
				case ($urandom_range(0, 7))
					0, 1: v = $urandom;
					2: v = $urandom_range(0, 300);
					3: v = -brac_pkg::VALUE_WIDTH'($urandom_range(1, 300));
					4: begin
						case ($urandom_range(0, 5))
							0: v = 32'd0;
							1: v = 32'd1;
							2: v = 32'hFFFF_FFFF;
							3: v = 32'h7FFF_FFFF;
							4: v = 32'h8000_0000;
							default: v = 32'h8000_0001;
						endcase
					end
					5: v = (32'd1 << $urandom_range(0, 31)) -
					       brac_pkg::VALUE_WIDTH'($urandom_range(0, 1));
					default: v = $urandom >> $urandom_range(0, 31);
				endcase
				send_value(v);
			end
		end

		// Drain the remaining text and give the block time to show stray beats.
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("binary_to_radix_ascii verification clean");
		end else begin
			$display("binary_to_radix_ascii verification failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20000000;
		$display("binary_to_radix_ascii verification failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/brac_pkg.sv
hw/rtl/brac_ram.sv
hw/rtl/brac_ctrl.sv
hw/rtl/brac_dp.sv
hw/rtl/binary_to_radix_ascii.sv
hw/rtl/brac_checker.sv
dv/radix_text_checker.sv
dv/testbench.sv
